@@ rtl/reference_governor_step_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the reference governor step block.
// Each macro samples on clk and is disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef REFERENCE_GOVERNOR_STEP_DEFINES_SVH
`define REFERENCE_GOVERNOR_STEP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define RGS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("reference governor check failed");
// Next-cycle implication.
`define RGS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("reference governor check failed");
`else
`define RGS_ASSERT_IMPL(lbl, ante, cons)
`define RGS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/rgs_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Reference governor step package
// Constants, register indexes, sequencer states and multiplier operations.
// ---------------------------------------------------------------------------
package rgs_pkg;

    // Prediction horizon and the width of its step counter.
    localparam int HORIZON_STEPS = 200;
    localparam int STEP_W = $clog2(HORIZON_STEPS + 1);

    // Per-step decay factors of the two modes, unsigned Q0.24.
    localparam logic [23:0] DECAY_FAST = 24'd16610280;
    localparam logic [23:0] DECAY_SLOW = 24'd16676854;

    // Gravity in signed Q28.17.
    localparam logic signed [44:0] GRAVITY_Q17 = 45'sd1285371;

    // Saturation limits used by the multiplier.
    localparam logic [63:0] CAP_S31 = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] CAP_S32 = 64'h0000_0000_8000_0000;
    localparam logic [63:0] CAP_BIG = 64'h4000_0000_0000_0000;
    localparam logic [63:0] CAP_NONE = 64'hFFFF_FFFF_FFFF_FFFF;

    // Register reset values.
    localparam logic        RST_ENABLE     = 1'b1;
    localparam logic [30:0] RST_THRUST_MAX = 31'd7821084;
    localparam logic [30:0] RST_THRUST_MIN = 31'd0;
    localparam logic [30:0] RST_GAIN       = 31'd65536;
    localparam logic [30:0] RST_FLOOR      = 31'd3277;
    localparam logic [30:0] RST_MASS       = 31'd131072;
    localparam logic [23:0] RST_STEP_TIME  = 24'd33554;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_ENABLE,
        REG_THRUST_MAX,
        REG_THRUST_MIN,
        REG_GAIN,
        REG_FLOOR,
        REG_MASS,
        REG_STEP_TIME
    } cfg_reg_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_MLO,
        S_MHI,
        S_WB,
        S_SQRT,
        S_LIMIT,
        S_DIST,
        S_NORM,
        S_DIVLD,
        S_DIV,
        S_FIN
    } state_t;

    // Operations run through the shared multiplier.
    typedef enum logic [2:0] {
        OP_TH,
        OP_SQ,
        OP_FAST,
        OP_SLOW,
        OP_MARGIN,
        OP_DSQ,
        OP_VDOT,
        OP_DELTA
    } op_t;

endpackage

@@ rtl/reference_governor_step.sv @@
`timescale 1ns / 1ps
// Each governed word runs 200 horizon steps; each step makes twelve passes of
// the shared 32x32 multiplier (states S_MLO, S_MHI, S_WB) plus a square root,
// and the update adds three divisions. First-tick and pass-through words go
// from S_IDLE straight to S_FIN. One word in flight at a time.
// Reset (rst_n, asynchronous, active low) restores register defaults, clears the
// applied reference and arms the first-tick latch.
// ---------------------------------------------------------------------------
// Reference governor step
// Predicts the closed-loop thrust over a horizon, forms a safety margin and
// moves the applied reference toward the goal, all on one shared multiplier.
// ---------------------------------------------------------------------------
`include "reference_governor_step_defines.svh"

module reference_governor_step
    import rgs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic signed [31:0] goal_x,
    input  logic signed [31:0] goal_y,
    input  logic signed [31:0] goal_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] ref_x,
    output logic signed [31:0] ref_y,
    output logic signed [31:0] ref_z,
    output logic signed [31:0] safety_margin,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    // Control state.
    state_t              state_reg, state_next;
    op_t                 op_reg;
    logic [1:0]          ax_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                dist_phase_reg;
    logic                first_tick_reg;
    logic [5:0]          div_cnt_reg;
    logic                out_valid_reg;

    // Configuration registers.
    logic                enable_reg;
    logic [30:0]         thrust_max_reg, thrust_min_reg, gain_reg, floor_reg, mass_reg;
    logic [23:0]         step_time_reg;

    // Applied reference and the word under work.
    logic signed [31:0]  aref_reg [3];
    logic signed [31:0]  pos_reg [3];
    logic signed [31:0]  vel_reg [3];
    logic signed [31:0]  goal_reg [3];
    logic signed [31:0]  pos_in [3];
    logic signed [31:0]  vel_in [3];
    logic signed [31:0]  goal_in [3];

    // Datapath registers.
    logic signed [43:0]  fast_reg [3];
    logic signed [43:0]  slow_reg [3];
    logic [30:0]         th_reg;
    logic [63:0]         sq_reg;
    logic [63:0]         sqrt_r_reg, sqrt_bit_reg;
    logic signed [34:0]  limit_reg;
    logic signed [31:0]  margin_reg;
    logic signed [32:0]  d_reg [3];
    logic                sh_reg;
    logic [32:0]         maxd_reg;
    logic [63:0]         div_n_reg, div_q_reg;
    logic [32:0]         div_rem_reg;
    logic [63:0]         vd_mag_reg;
    logic                vd_neg_reg;
    logic [95:0]         mul_acc_reg;
    logic signed [31:0]  out_ref_reg [3];
    logic signed [31:0]  out_margin_reg;

    // Combinational signals.
    logic                accept;
    logic                out_free;
    logic                last_ax;
    logic signed [44:0]  acc_sum;
    logic [63:0]         mul_a;
    logic [31:0]         mul_b;
    logic [4:0]          mul_sh;
    logic [63:0]         mul_cap;
    logic [31:0]         mul_x;
    logic [63:0]         mul_p;
    logic [95:0]         mul_half, mul_rnd, mul_q;
    logic [63:0]         mul_res;
    logic [32:0]         d_mag;
    logic [32:0]         dsq_op;
    logic [32:0]         margin_mag;
    logic [63:0]         sqrt_t;
    logic                sqrt_ge;
    logic [33:0]         rem_sh;
    logic                div_ge;
    logic signed [34:0]  n_s, tmax_s, tmin_s, dmax, dmin, lim_a, lim_b;
    logic signed [63:0]  delta, ref_sum;
    logic signed [31:0]  ref_clamped;
    logic [32:0]         norm, floorv;
    logic                dist_big;

    function automatic logic [63:0] mag64(input logic signed [63:0] x);
        mag64 = x[63] ? 64'(-x) : 64'(x);
    endfunction

    assign pos_in  = '{pos_x, pos_y, pos_z};
    assign vel_in  = '{vel_x, vel_y, vel_z};
    assign goal_in = '{goal_x, goal_y, goal_z};

    // Handshake decode.
    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        cfg_ready = 1'b1;
        accept    = in_valid && (state_reg == S_IDLE);
        out_free  = !out_valid_reg || out_ready;
        last_ax   = (ax_reg == 2'd2);
    end

    assign out_valid     = out_valid_reg;
    assign ref_x         = out_ref_reg[0];
    assign ref_y         = out_ref_reg[1];
    assign ref_z         = out_ref_reg[2];
    assign safety_margin = out_margin_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        acc_sum = 45'(fast_reg[ax_reg]) + 45'(slow_reg[ax_reg])
                  + (last_ax ? GRAVITY_Q17 : 45'sd0);
        d_mag = 33'(mag64(64'(d_reg[ax_reg])));
        dsq_op = d_mag >> sh_reg;
        margin_mag = 33'(mag64(64'(margin_reg)));
        mul_a = '0;
        mul_b = '0;
        mul_sh = 5'd0;
        mul_cap = CAP_NONE;
        unique case (op_reg)
            OP_TH:
            begin
                mul_a = mag64(64'(acc_sum));
                mul_b = {1'b0, mass_reg};
                mul_sh = 5'd17;
                mul_cap = CAP_S31;
            end
            OP_SQ:
            begin
                mul_a = 64'(th_reg);
                mul_b = {1'b0, th_reg};
            end
            OP_FAST:
            begin
                mul_a = mag64(64'(fast_reg[ax_reg]));
                mul_b = 32'(DECAY_FAST);
                mul_sh = 5'd24;
                mul_cap = CAP_BIG;
            end
            OP_SLOW:
            begin
                mul_a = mag64(64'(slow_reg[ax_reg]));
                mul_b = 32'(DECAY_SLOW);
                mul_sh = 5'd24;
                mul_cap = CAP_BIG;
            end
            OP_MARGIN:
            begin
                mul_a = mag64(64'(limit_reg));
                mul_b = {1'b0, gain_reg};
                mul_sh = 5'd16;
                mul_cap = CAP_S32;
            end
            OP_DSQ:
            begin
                mul_a = 64'(dsq_op);
                mul_b = dsq_op[31:0];
            end
            OP_VDOT:
            begin
                mul_a = div_q_reg;
                mul_b = margin_mag[31:0];
                mul_sh = 5'd30;
                mul_cap = CAP_BIG;
            end
            OP_DELTA:
            begin
                mul_a = vd_mag_reg;
                mul_b = 32'(step_time_reg);
                mul_sh = 5'd24;
                mul_cap = CAP_BIG;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // Shared 32x32 multiplier, low half then high half of operand a.
    assign mul_x = (state_reg == S_MHI) ? mul_a[63:32] : mul_a[31:0];
    assign mul_p = mul_x * mul_b;

    // Rounding half away from zero on the magnitude, then saturation.
    always_comb
    begin
        mul_half = (mul_sh == 5'd0) ? 96'd0 : (96'd1 << (mul_sh - 5'd1));
        mul_rnd  = mul_acc_reg + mul_half;
        mul_q    = mul_rnd >> mul_sh;
        mul_res  = (mul_q > {32'd0, mul_cap}) ? mul_cap : mul_q[63:0];
    end

    // Square root step, division step, limit update, norm and floor, and reference update.
    always_comb
    begin
        sqrt_t  = sqrt_r_reg + sqrt_bit_reg;
        sqrt_ge = (sq_reg >= sqrt_t);
        rem_sh  = {div_rem_reg, div_n_reg[63]};
        div_ge  = (rem_sh >= {1'b0, maxd_reg});
        n_s     = $signed({3'b000, sqrt_r_reg[31:0]});
        tmax_s  = $signed({4'b0000, thrust_max_reg});
        tmin_s  = $signed({4'b0000, thrust_min_reg});
        dmax    = tmax_s - n_s;
        dmin    = n_s - tmin_s;
        lim_a   = (dmax < limit_reg) ? dmax : limit_reg;
        lim_b   = (dmin < lim_a) ? dmin : lim_a;
        norm    = {1'b0, sqrt_r_reg[31:0]} << sh_reg;
        floorv  = (floor_reg == 31'd0) ? 33'd1 : {2'b00, floor_reg};
        delta   = vd_neg_reg ? -$signed(mul_res) : $signed(mul_res);
        ref_sum = 64'(aref_reg[ax_reg]) + delta;
        if (ref_sum > 64'sd2147483647)
        begin
            ref_clamped = 32'sh7FFF_FFFF;
        end
        else if (ref_sum < -64'sd2147483648)
        begin
            ref_clamped = 32'sh8000_0000;
        end
        else
        begin
            ref_clamped = ref_sum[31:0];
        end
    end

    // Halving flag for very large goal offsets.
    always_comb
    begin
        dist_big = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (mag64(64'(goal_reg[i]) - 64'(aref_reg[i])) >= 64'd2147483648)
            begin
                dist_big = 1'b1;
            end
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (first_tick_reg || !enable_reg) ? S_FIN : S_INIT;
                end
            end
            S_INIT:  state_next = S_MLO;
            S_MLO:   state_next = S_MHI;
            S_MHI:   state_next = S_WB;
            S_WB:
            begin
                unique case (op_reg)
                    OP_SLOW, OP_DSQ: state_next = last_ax ? S_SQRT : S_MLO;
                    OP_MARGIN:       state_next = S_DIST;
                    OP_DELTA:        state_next = last_ax ? S_FIN : S_DIVLD;
                    default:         state_next = S_MLO;
                endcase
            end
            S_SQRT:
            begin
                if (sqrt_bit_reg[0])
                begin
                    state_next = dist_phase_reg ? S_NORM : S_LIMIT;
                end
            end
            S_LIMIT: state_next = S_MLO;
            S_DIST:  state_next = S_MLO;
            S_NORM:  state_next = S_DIVLD;
            S_DIVLD: state_next = S_DIV;
            S_DIV:
            begin
                if (div_cnt_reg == 6'd63)
                begin
                    state_next = S_MLO;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers, configuration and applied reference.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_TH;
            ax_reg         <= 2'd0;
            step_reg       <= '0;
            dist_phase_reg <= 1'b0;
            first_tick_reg <= 1'b1;
            div_cnt_reg    <= 6'd0;
            out_valid_reg  <= 1'b0;
            enable_reg     <= RST_ENABLE;
            thrust_max_reg <= RST_THRUST_MAX;
            thrust_min_reg <= RST_THRUST_MIN;
            gain_reg       <= RST_GAIN;
            floor_reg      <= RST_FLOOR;
            mass_reg       <= RST_MASS;
            step_time_reg  <= RST_STEP_TIME;
            aref_reg       <= '{32'sd0, 32'sd0, 32'sd0};
        end
        else
        begin
            state_reg <= state_next;

            // Configuration writes.
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_ENABLE:     enable_reg     <= cfg_data[0];
                    REG_THRUST_MAX: thrust_max_reg <= cfg_data[30:0];
                    REG_THRUST_MIN: thrust_min_reg <= cfg_data[30:0];
                    REG_GAIN:       gain_reg       <= cfg_data[30:0];
                    REG_FLOOR:      floor_reg      <= cfg_data[30:0];
                    REG_MASS:       mass_reg       <= cfg_data[30:0];
                    REG_STEP_TIME:  step_time_reg  <= cfg_data[23:0];
                    default:        enable_reg     <= enable_reg;
                endcase
            end

            // Output word register.
            if (state_reg == S_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (first_tick_reg)
                        begin
                            aref_reg       <= pos_in;
                            first_tick_reg <= 1'b0;
                        end
                        else if (!enable_reg)
                        begin
                            aref_reg <= goal_in;
                        end
                    end
                end
                S_INIT:
                begin
                    op_reg         <= OP_TH;
                    ax_reg         <= 2'd0;
                    step_reg       <= '0;
                    dist_phase_reg <= 1'b0;
                end
                S_WB:
                begin
                    unique case (op_reg)
                        OP_TH:   op_reg <= OP_SQ;
                        OP_SQ:   op_reg <= OP_FAST;
                        OP_FAST: op_reg <= OP_SLOW;
                        OP_SLOW:
                        begin
                            op_reg <= OP_TH;
                            ax_reg <= last_ax ? 2'd0 : ax_reg + 2'd1;
                        end
                        OP_DSQ:
                        begin
                            ax_reg <= last_ax ? 2'd0 : ax_reg + 2'd1;
                        end
                        OP_VDOT: op_reg <= OP_DELTA;
                        OP_DELTA:
                        begin
                            aref_reg[ax_reg] <= ref_clamped;
                            if (!last_ax)
                            begin
                                ax_reg <= ax_reg + 2'd1;
                            end
                        end
                        default: op_reg <= op_reg;
                    endcase
                end
                S_LIMIT:
                begin
                    if (step_reg == STEP_W'(HORIZON_STEPS - 1))
                    begin
                        op_reg <= OP_MARGIN;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_DIST:
                begin
                    op_reg         <= OP_DSQ;
                    ax_reg         <= 2'd0;
                    dist_phase_reg <= 1'b1;
                end
                S_DIVLD: div_cnt_reg <= 6'd0;
                S_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                    if (div_cnt_reg == 6'd63)
                    begin
                        op_reg <= OP_VDOT;
                    end
                end
                default: op_reg <= op_reg;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pos_reg    <= pos_in;
                    vel_reg    <= vel_in;
                    goal_reg   <= goal_in;
                    margin_reg <= 32'sd0;
                end
            end
            S_INIT:
            begin
                // Modal terms from position error and velocity.
                for (int i = 0; i < 3; i++)
                begin
                    fast_reg[i] <= -(44'sd25 * (44'sd3 * (44'(pos_reg[i]) - 44'(aref_reg[i]))
                                     + 44'(vel_reg[i])));
                    slow_reg[i] <= 44'sd9 * (44'sd5 * (44'(pos_reg[i]) - 44'(aref_reg[i]))
                                  + 44'(vel_reg[i]));
                end
                limit_reg <= $signed({4'b0000, thrust_max_reg});
                sq_reg    <= 64'd0;
            end
            S_MLO: mul_acc_reg <= 96'(mul_p);
            S_MHI: mul_acc_reg <= mul_acc_reg + {mul_p, 32'd0};
            S_WB:
            begin
                unique case (op_reg)
                    OP_TH: th_reg <= mul_res[30:0];
                    OP_SQ, OP_DSQ:
                    begin
                        sq_reg <= sq_reg + mul_acc_reg[63:0];
                        if (op_reg == OP_DSQ || last_ax)
                        begin
                            sqrt_r_reg   <= 64'd0;
                            sqrt_bit_reg <= 64'd1 << 62;
                        end
                    end
                    OP_FAST:
                    begin
                        fast_reg[ax_reg] <= fast_reg[ax_reg][43] ? -$signed(mul_res[43:0])
                                                                 : $signed(mul_res[43:0]);
                    end
                    OP_SLOW:
                    begin
                        slow_reg[ax_reg] <= slow_reg[ax_reg][43] ? -$signed(mul_res[43:0])
                                                                 : $signed(mul_res[43:0]);
                    end
                    OP_MARGIN:
                    begin
                        if (limit_reg[34])
                        begin
                            margin_reg <= -$signed(mul_res[31:0]);
                        end
                        else if (mul_res == CAP_S32)
                        begin
                            margin_reg <= 32'sh7FFF_FFFF;
                        end
                        else
                        begin
                            margin_reg <= $signed(mul_res[31:0]);
                        end
                    end
                    OP_VDOT:
                    begin
                        vd_mag_reg <= mul_res;
                        vd_neg_reg <= d_reg[ax_reg][32] ^ margin_reg[31];
                    end
                    default: th_reg <= th_reg;
                endcase
            end
            S_SQRT:
            begin
                // One result bit of the integer square root per cycle.
                if (sqrt_ge)
                begin
                    sq_reg     <= sq_reg - sqrt_t;
                    sqrt_r_reg <= (sqrt_r_reg >> 1) + sqrt_bit_reg;
                end
                else
                begin
                    sqrt_r_reg <= sqrt_r_reg >> 1;
                end
                sqrt_bit_reg <= sqrt_bit_reg >> 2;
            end
            S_LIMIT:
            begin
                limit_reg <= lim_b;
                sq_reg    <= 64'd0;
            end
            S_DIST:
            begin
                // Goal offsets and the halving flag for very large offsets.
                sh_reg <= dist_big;
                for (int i = 0; i < 3; i++)
                begin
                    d_reg[i] <= 33'(goal_reg[i]) - 33'(aref_reg[i]);
                end
                sq_reg <= 64'd0;
            end
            S_NORM: maxd_reg <= (norm > floorv) ? norm : floorv;
            S_DIVLD:
            begin
                div_n_reg   <= (64'(d_mag) << 30) + 64'(maxd_reg >> 1);
                div_rem_reg <= 33'd0;
                div_q_reg   <= 64'd0;
            end
            S_DIV:
            begin
                // Restoring division, one quotient bit per cycle.
                div_rem_reg <= div_ge ? 33'(rem_sh - {1'b0, maxd_reg}) : rem_sh[32:0];
                div_n_reg   <= {div_n_reg[62:0], 1'b0};
                div_q_reg   <= {div_q_reg[62:0], div_ge};
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_ref_reg    <= aref_reg;
                    out_margin_reg <= margin_reg;
                end
            end
            default: th_reg <= th_reg;
        endcase
    end

    // Checks.
    `RGS_ASSERT_NEXT(a_one_word, in_valid && in_ready, !in_ready)
    `RGS_ASSERT_IMPL(a_div_rem, state_reg == S_DIV, div_rem_reg < maxd_reg)
    `RGS_ASSERT_IMPL(a_step_range, 1'b1, step_reg <= STEP_W'(HORIZON_STEPS - 1))
    `RGS_ASSERT_IMPL(a_root_width, state_reg == S_LIMIT, sqrt_r_reg[63:32] == 32'd0)

endmodule
